>>> sv/cpse_pkg.sv
// ----------------------------------------------------------------------------
// cpse_pkg
// Shared sizes, types and widths for the changed pixel span encoder.
// ----------------------------------------------------------------------------
package cpse_pkg;

  localparam int unsigned LINE_PIXELS = 320;
  localparam int unsigned FRAME_ROWS  = 240;
  localparam int unsigned FRAME_SIZE  = LINE_PIXELS * FRAME_ROWS;

  localparam int unsigned COL_W  = $clog2(LINE_PIXELS);
  localparam int unsigned ROW_W  = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
  localparam int unsigned ADDR_W = $clog2(FRAME_SIZE);

  localparam int unsigned PIX_W   = 24;
  localparam int unsigned SROW_W  = 8;
  localparam int unsigned SCOL_W  = 9;
  localparam int unsigned SPAN_W  = SROW_W + 2 * SCOL_W + PIX_W;
  localparam int unsigned TDATA_W = ((SPAN_W + 7) / 8) * 8;
  localparam int unsigned IDATA_W = ((PIX_W + 7) / 8) * 8;

  // Span queue; intake reserves room for two spans per pixel in flight.
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  typedef logic [PIX_W-1:0] pixel_t;

  // Lowest bits first: row, first, final, color.
  typedef struct packed {
    logic [PIX_W-1:0]  color;
    logic [SCOL_W-1:0] final_col;
    logic [SCOL_W-1:0] first_col;
    logic [SROW_W-1:0] row;
  } span_t;

  typedef struct packed {
    logic  last;
    span_t span;
  } fifo_entry_t;

endpackage

>>> sv/changed_pixel_span_encoder.sv
// ----------------------------------------------------------------------------
// changed_pixel_span_encoder
// Compares each raster pixel with the previous frame store and emits spans
// of changed pixels that share one color.
// ----------------------------------------------------------------------------
// Path: an accepted pixel is registered into the compare stage, and the
//   spans it closes are written into the 8-entry span queue, which offers
//   them; a span may wait there behind earlier spans or an output stall.
// Throughput: one pixel per cycle while the span queue has room; the frame
//   store does one read-first access per pixel; a two-span pixel queues both.
// Reset: counters, open-span state and queue clear at once. The frame store
//   is not swept; a flag makes it read as zero until the first frame is full.
module changed_pixel_span_encoder
  import cpse_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [IDATA_W-1:0] s_axis_tdata_i,   // [23:0] pixel_color
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,   // [7:0] span_row, [16:8] span_first,
                                               // [25:17] span_final, [49:26] span_color
  output logic               m_axis_tlast_o    // last_of_item
);

  // Frame store
  pixel_t frame_mem [FRAME_SIZE];
  pixel_t rd_q;

  // Position counters and fill flag
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              fresh_q, fresh_d;
  logic              in_acc;
  logic              last_col;

  // Compare stage
  logic             s1_valid_q;
  pixel_t           s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic             s1_last_col_q;
  logic             s1_fresh_q;

  // Open span
  logic             run_active_q, run_active_d;
  pixel_t           run_color_q, run_color_d;
  logic [COL_W-1:0] run_start_q, run_start_d;

  pixel_t      prev_pix;
  logic        changed;
  logic        span_a_v, span_b_v;
  fifo_entry_t span_a, span_b;

  // Span queue
  fifo_entry_t           fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d, n_wr, free_slots, need_slots;
  logic                  pop;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign last_col = (col_q == COL_W'(LINE_PIXELS - 1));

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    addr_d  = addr_q;
    fresh_d = fresh_q;
    if (in_acc) begin
      if (last_col) begin
        col_d = '0;
        row_d = (row_q == ROW_W'(FRAME_ROWS - 1)) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
      if (addr_q == ADDR_W'(FRAME_SIZE - 1)) begin
        addr_d  = '0;
        fresh_d = 1'b0;
      end else begin
        addr_d = addr_q + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      addr_q     <= '0;
      fresh_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      addr_q     <= addr_d;
      fresh_q    <= fresh_d;
      s1_valid_q <= in_acc;
    end
  end

  // Read the old color and write the new one at the same address.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_mem[addr_q] <= s_axis_tdata_i[PIX_W-1:0];
      rd_q              <= frame_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q      <= s_axis_tdata_i[PIX_W-1:0];
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_last_col_q <= last_col;
      s1_fresh_q    <= fresh_q;
    end
  end

  assign prev_pix = s1_fresh_q ? '0 : rd_q;
  assign changed  = (s1_pix_q != prev_pix);

  always_comb begin
    span_a_v     = 1'b0;
    span_b_v     = 1'b0;
    run_active_d = run_active_q;
    run_color_d  = run_color_q;
    run_start_d  = run_start_q;
    if (s1_valid_q) begin
      if (changed) begin
        if (run_active_d && (run_color_q != s1_pix_q)) begin
          span_a_v     = 1'b1;
          run_active_d = 1'b0;
        end
        if (!run_active_d) begin
          run_active_d = 1'b1;
          run_color_d  = s1_pix_q;
          run_start_d  = s1_col_q;
        end
      end else if (run_active_d) begin
        span_a_v     = 1'b1;
        run_active_d = 1'b0;
      end
      // Close any open span at the row end.
      if (s1_last_col_q && run_active_d) begin
        span_b_v     = 1'b1;
        run_active_d = 1'b0;
      end
    end
  end

  always_comb begin
    span_a.last           = !span_b_v;
    span_a.span.row       = SROW_W'(s1_row_q);
    span_a.span.first_col = SCOL_W'(run_start_q);
    span_a.span.final_col = SCOL_W'(s1_col_q - COL_W'(1));
    span_a.span.color     = run_color_q;
    span_b.last           = 1'b1;
    span_b.span.row       = SROW_W'(s1_row_q);
    span_b.span.first_col = SCOL_W'(run_start_d);
    span_b.span.final_col = SCOL_W'(s1_col_q);
    span_b.span.color     = run_color_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
      run_color_q  <= '0;
      run_start_q  <= '0;
    end else begin
      run_active_q <= run_active_d;
      run_color_q  <= run_color_d;
      run_start_q  <= run_start_d;
    end
  end

  // Span queue: up to two writes and one read per cycle.
  assign pop        = m_axis_tvalid_o && m_axis_tready_i;
  assign n_wr       = FIFO_CNT_W'(span_a_v) + FIFO_CNT_W'(span_b_v);
  assign cnt_d      = cnt_q + n_wr - FIFO_CNT_W'(pop);
  assign wr_ptr_d   = wr_ptr_q + FIFO_PTR_W'(n_wr);
  assign rd_ptr_d   = rd_ptr_q + FIFO_PTR_W'(pop);
  assign free_slots = FIFO_CNT_W'(FIFO_DEPTH) - cnt_q;
  assign need_slots = s1_valid_q ? FIFO_CNT_W'(4) : FIFO_CNT_W'(2);

  assign s_axis_tready_o = (free_slots >= need_slots);

  always_ff @(posedge clk_i) begin
    if (span_a_v) begin
      fifo_mem[wr_ptr_q] <= span_a;
    end
    if (span_b_v) begin
      fifo_mem[wr_ptr_q + FIFO_PTR_W'(span_a_v)] <= span_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = TDATA_W'(fifo_mem[rd_ptr_q].span);
  assign m_axis_tlast_o  = fifo_mem[rd_ptr_q].last;

endmodule

>>> sv/cpse_checker.sv
// ----------------------------------------------------------------------------
// cpse_checker
// Port-level checks on the span output of the changed pixel span encoder.
// ----------------------------------------------------------------------------
module cpse_checker
  import cpse_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tlast_o
);

  logic              out_acc;
  logic              pend_q;
  logic [SROW_W-1:0] pend_row_q;
  logic [SCOL_W-1:0] pend_final_q;
  logic [SROW_W-1:0] o_row;
  logic [SCOL_W-1:0] o_first, o_final;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;
  assign o_row   = m_axis_tdata_o[SROW_W-1:0];
  assign o_first = m_axis_tdata_o[SROW_W +: SCOL_W];
  assign o_final = m_axis_tdata_o[SROW_W+SCOL_W +: SCOL_W];

  // Remember a span that is not the last one of its pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= 1'b0;
      pend_row_q   <= '0;
      pend_final_q <= '0;
    end else if (out_acc) begin
      pend_q       <= !m_axis_tlast_o;
      pend_row_q   <= o_row;
      pend_final_q <= o_final;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("span changed while stalled");

  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> o_first <= o_final)
    else $error("span ends before it starts");

  a_pair_adjacent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && pend_q |->
      m_axis_tlast_o && (o_row == pend_row_q) && (o_first == pend_final_q + SCOL_W'(1)))
    else $error("second span of a pixel does not follow the first");

  a_no_out_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("span offered right after reset");

endmodule

bind changed_pixel_span_encoder cpse_checker u_cpse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> bench/changed_pixel_span_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// changed_pixel_span_encoder_tb
// Streams raster pixels through the span encoder and checks every span it
// emits. A local model of the frame store and the open span predicts each
// span. The stimulus starts with fixed pixels and forced row-end cases on
// the first rows and ends with a short stretch of random pixels.
// ----------------------------------------------------------------------------
module changed_pixel_span_encoder_tb;
  import cpse_pkg::*;

  logic               clk_i;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [IDATA_W-1:0] s_axis_tdata_i  = '0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic               m_axis_tlast_o;

  changed_pixel_span_encoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Pixel plan, built up front
  pixel_t      pixel_q[$];
  pixel_t      frame_plan [FRAME_SIZE];
  int unsigned plan_pos;
  pixel_t      last_planned;
  pixel_t      row_tint [2];

  // Span prediction
  pixel_t        seen_frame [FRAME_SIZE];
  int unsigned   seen_col;
  int unsigned   seen_row;
  bit            span_open;
  pixel_t        open_color;
  int unsigned   open_first;
  fifo_entry_t   spans_expected_q[$];

  int unsigned pixels_total;
  int unsigned pixels_accepted;
  int unsigned double_span_pixels;
  int unsigned spans_checked;
  int unsigned mismatch_count;
  int unsigned source_gap;
  int unsigned source_calm;
  int unsigned sink_hold;
  int unsigned sink_calm;

  function automatic int unsigned next_pause(inout int unsigned calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 2) begin
      calm = $urandom_range(40, 200);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic push_pixel(input pixel_t p);
    pixel_q = {pixel_q, p};
    frame_plan[plan_pos] = p;
    last_planned = p;
    plan_pos = (plan_pos + 1 == FRAME_SIZE) ? 0 : plan_pos + 1;
    if (plan_pos % LINE_PIXELS == 0) begin
      row_tint[0] = pixel_t'($urandom());
      row_tint[1] = pixel_t'($urandom());
    end
  endtask

  // Mix span growth, unchanged pixels, one-bit near misses and fresh colors.
  function automatic pixel_t random_pixel();
    int unsigned r;
    pixel_t stored;
    r = $urandom_range(0, 99);
    stored = frame_plan[plan_pos];
    if (r < 30) return last_planned;
    if (r < 50) return stored;
    if (r < 60) return stored ^ (pixel_t'(1) << $urandom_range(0, PIX_W - 1));
    if (r < 68) return '0;
    if (r < 74) return '1;
    if (r < 86) return row_tint[$urandom_range(0, 1)];
    return pixel_t'($urandom());
  endfunction

  task automatic fill_to_column(input int unsigned col);
    while (plan_pos % LINE_PIXELS != col) push_pixel(random_pixel());
  endtask

  function automatic fifo_entry_t close_open_span(input int unsigned end_col);
    fifo_entry_t e;
    e.span.row       = SROW_W'(seen_row);
    e.span.first_col = SCOL_W'(open_first);
    e.span.final_col = SCOL_W'(end_col);
    e.span.color     = open_color;
    e.last           = 1'b0;
    span_open        = 1'b0;
    return e;
  endfunction

  task automatic predict_spans(input pixel_t pix);
    int unsigned addr;
    fifo_entry_t made [2];
    int          n;
    addr = seen_row * LINE_PIXELS + seen_col;
    n = 0;
    if (pix != seen_frame[addr]) begin
      if (span_open && open_color != pix) begin
        made[n] = close_open_span(seen_col - 1);
        n++;
      end
      if (!span_open) begin
        span_open  = 1'b1;
        open_color = pix;
        open_first = seen_col;
      end
    end else if (span_open) begin
      made[n] = close_open_span(seen_col - 1);
      n++;
    end
    // no span crosses a row
    if (seen_col == LINE_PIXELS - 1 && span_open) begin
      made[n] = close_open_span(seen_col);
      n++;
    end
    seen_frame[addr] = pix;
    for (int i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      spans_expected_q = {spans_expected_q, made[i]};
    end
    if (n == 2) double_span_pixels++;
    if (seen_col + 1 >= LINE_PIXELS) begin
      seen_col = 0;
      seen_row = (seen_row + 1 >= FRAME_ROWS) ? 0 : seen_row + 1;
    end else begin
      seen_col++;
    end
  endtask

  task automatic check_span();
    span_t       got;
    fifo_entry_t want;
    got = span_t'(m_axis_tdata_o[SPAN_W-1:0]);
    spans_checked++;
    if (spans_expected_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: span with none pending: row %0d cols %0d..%0d color %06h last %0b",
                 $realtime, got.row, got.first_col, got.final_col, got.color,
                 m_axis_tlast_o);
      return;
    end
    want = spans_expected_q.pop_front();
    if (got.row !== want.span.row || got.first_col !== want.span.first_col ||
        got.final_col !== want.span.final_col || got.color !== want.span.color ||
        m_axis_tlast_o !== want.last || (m_axis_tdata_o >> SPAN_W) !== '0) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: span %0d mismatch", $realtime, spans_checked);
        $display("  expected row %0d cols %0d..%0d color %06h last %0b",
                 want.span.row, want.span.first_col, want.span.final_col,
                 want.span.color, want.last);
        $display("  actual   row %0d cols %0d..%0d color %06h last %0b tdata %h",
                 got.row, got.first_col, got.final_col, got.color, m_axis_tlast_o,
                 m_axis_tdata_o);
      end
    end
  endtask

  // Source side: predict on each accepted pixel, then refill or idle.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predict_spans(pixel_t'(s_axis_tdata_i));
        pixels_accepted++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (source_gap > 0) begin
          source_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pixel_q.pop_front();
          source_gap = next_pause(source_calm);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Sink side: check each accepted span, stall at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) check_span();
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        sink_hold = next_pause(sink_calm);
      end
    end
  end

  initial begin
    plan_pos = 0;
    last_planned = '0;
    row_tint[0] = pixel_t'($urandom());
    row_tint[1] = pixel_t'($urandom());
    for (int i = 0; i < FRAME_SIZE; i++) begin
      frame_plan[i] = '0;
      seen_frame[i] = '0;
    end
    seen_col = 0;
    seen_row = 0;
    span_open = 1'b0;
    open_color = '0;
    open_first = 0;
    pixels_accepted = 0;
    double_span_pixels = 0;
    spans_checked = 0;
    mismatch_count = 0;
    source_gap = 0;
    source_calm = 0;
    sink_hold = 0;
    sink_calm = 0;

    // Unchanged start, a white run, color switch, bit extremes, near misses.
    push_pixel(24'h000000); push_pixel(24'hFFFFFF); push_pixel(24'hFFFFFF);
    push_pixel(24'hFFFFFF); push_pixel(24'h000000); push_pixel(24'h123456);
    push_pixel(24'h654321); push_pixel(24'h654321); push_pixel(24'hAAAAAA);
    push_pixel(24'h555555); push_pixel(24'h800000); push_pixel(24'h000001);
    push_pixel(24'h000000); push_pixel(24'hFFFFFF); push_pixel(24'hFFFFFE);
    push_pixel(24'h7FFFFF); push_pixel(24'h000000);

    // Row 0 ends on a color change: two spans from the last pixel.
    fill_to_column(LINE_PIXELS - 2);
    push_pixel(24'h00FF00);
    push_pixel(24'h0000FF);
    // Row 1: open span runs into the row end.
    fill_to_column(LINE_PIXELS - 2);
    push_pixel(24'hC0FFEE);
    push_pixel(24'hC0FFEE);
    // Row 2: unchanged last pixel closes the span one column early.
    fill_to_column(LINE_PIXELS - 2);
    push_pixel(24'h00FFFF);
    push_pixel(frame_plan[plan_pos]);
    // Row 3: lone changed pixel at the last column.
    fill_to_column(LINE_PIXELS - 2);
    push_pixel(frame_plan[plan_pos]);
    push_pixel(24'hFF00FF);

    repeat (20) push_pixel(random_pixel());
    pixels_total = pixel_q.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pixels_accepted != pixels_total) @(posedge clk_i);
    while (spans_expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Streamed %0d pixels over the first rows with forced row-end cases.",
             pixels_accepted);
    $display("Checked %0d spans; %0d pixels closed two spans, %0d mismatches.",
             spans_checked, double_span_pixels, mismatch_count);
    if (mismatch_count == 0 && spans_expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
